@@ hdl/rgb_median_filter_window_defines.svh @@
// Assertion macros used by the median filter top level.
`ifndef RGB_MEDIAN_FILTER_WINDOW_DEFINES_SVH
`define RGB_MEDIAN_FILTER_WINDOW_DEFINES_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define RMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_median_filter_window: check failed");

// consequent must hold in the cycle after the antecedent
`define RMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_median_filter_window: check failed");

`else

`define RMF_ASSERT_NOW(label, ante, cons)
`define RMF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/rmf_pkg.sv @@
// Package: constants and types of the RGB median filter.
`default_nettype none

package rmf_pkg;

  localparam int WINDOW        = 3;
  localparam int N_SAMP        = WINDOW * WINDOW;
  localparam int MED_IDX       = N_SAMP / 2;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int FW_W   = 11;
  localparam int FH_W   = 12;
  localparam int CFG_W  = 12;
  localparam int CFG_IW = 1;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

endpackage

`default_nettype wire

@@ hdl/rmf_stream_if.sv @@
// Interfaces: pixel input channel and filtered result channel.
`default_nettype none

interface rmf_pix_if;
  logic                    valid;
  logic                    ready;
  logic [rmf_pkg::CH_W-1:0] blue;
  logic [rmf_pkg::CH_W-1:0] green;
  logic [rmf_pkg::CH_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

interface rmf_res_if;
  logic                    valid;
  logic                    ready;
  logic [rmf_pkg::CH_W-1:0] blue_median;
  logic [rmf_pkg::CH_W-1:0] green_median;
  logic [rmf_pkg::CH_W-1:0] red_median;
  logic                    line_end;
  logic                    frame_end;

  modport source (output valid, blue_median, green_median, red_median, line_end, frame_end,
                  input ready);
  modport sink   (input valid, blue_median, green_median, red_median, line_end, frame_end,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/rmf_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/rmf_median.sv @@
// Median of one channel over the window, by rank selection.
`default_nettype none

module rmf_median (
  input  wire logic [rmf_pkg::N_SAMP-1:0][rmf_pkg::CH_W-1:0] samples,
  output      logic [rmf_pkg::CH_W-1:0]                       median
);

  localparam int RANK_W = $clog2(rmf_pkg::N_SAMP);

  logic [RANK_W-1:0] rank [rmf_pkg::N_SAMP];

  // rank = number of samples ordered ahead; ties broken by position so
  // ranks form a permutation and exactly one sample holds the middle rank
  always_comb begin
    for (int i = 0; i < rmf_pkg::N_SAMP; i++) begin
      rank[i] = '0;
      for (int j = 0; j < rmf_pkg::N_SAMP; j++) begin
        if (j != i) begin
          if ((samples[j] < samples[i]) || ((samples[j] == samples[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < rmf_pkg::N_SAMP; i++) begin
      if (rank[i] == RANK_W'(rmf_pkg::MED_IDX)) begin
        median = median | samples[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rgb_median_filter_window.sv @@
// Top level: streaming RGB window median filter with line store.
//
//  channel   | dir  | handshake           | payload
//  ----------+------+---------------------+------------------------------------------
//  in_ch     | in   | valid/ready         | blue, green, red
//  out_ch    | out  | valid/ready         | blue/green/red_median, line_end, frame_end
//  cfg_*     | in   | cfg_we, no wait     | cfg_index, cfg_wdata
//
// One pixel is taken per clock while the output is not backed up; each result moves
// from stage 1 (line-store read) through stage 2 (window) into the output register,
// from which it can transfer out. The extra stage comes from the line store: one
// registered read and one write per pixel on each line RAM.
// Reset (synchronous, rst_n low) clears counters, stage valids and the window;
// the line store is not cleared. out_ch.ready low holds the result register and
// backs up through both stages to in_ch.ready.
`default_nettype none
`include "rgb_median_filter_window_defines.svh"

module rgb_median_filter_window #(
  parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rmf_pix_if.sink                          in_ch,
  rmf_res_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [rmf_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [rmf_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int W   = rmf_pkg::WINDOW;
  localparam int NL  = W - 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > rmf_pkg::FW_W) ?
                       $clog2(MAX_WIDTH + 1) : rmf_pkg::FW_W;
  localparam int FH_W = rmf_pkg::FH_W;

  // configuration and position
  logic [rmf_pkg::FW_W-1:0] fw_r;
  logic [FH_W-1:0]          fh_r;
  logic [CW-1:0]            col_r;
  logic [FH_W-1:0]          row_r;
  logic [WW-1:0]            fw_ext;
  logic [WW-1:0]            eff_w;
  logic [FH_W-1:0]          eff_h;
  logic                     last_col;
  logic                     last_row;
  logic                     emit;

  // stage 1: line-store read in flight
  logic                     s1_valid_r;
  rmf_pkg::pix_t            s1_pix_r;
  logic [CW-1:0]            s1_col_r;
  logic                     s1_emit_r;
  logic                     s1_le_r;
  logic                     s1_fe_r;

  // stage 2: window holds the item
  logic                     s2_valid_r;
  logic                     s2_le_r;
  logic                     s2_fe_r;
  rmf_pkg::pix_t            window_r [W][W];

  // result register
  logic                     out_valid_r;
  logic [rmf_pkg::CH_W-1:0] out_blue_r;
  logic [rmf_pkg::CH_W-1:0] out_green_r;
  logic [rmf_pkg::CH_W-1:0] out_red_r;
  logic                     out_le_r;
  logic                     out_fe_r;

  logic                     accept;
  logic                     s1_adv;
  logic                     s2_adv;

  rmf_pkg::pix_t            rd_pix [NL];
  rmf_pkg::pix_t            wr_pix [NL];

  logic [rmf_pkg::N_SAMP-1:0][rmf_pkg::CH_W-1:0] blue_s;
  logic [rmf_pkg::N_SAMP-1:0][rmf_pkg::CH_W-1:0] green_s;
  logic [rmf_pkg::N_SAMP-1:0][rmf_pkg::CH_W-1:0] red_s;
  logic [rmf_pkg::CH_W-1:0] blue_med;
  logic [rmf_pkg::CH_W-1:0] green_med;
  logic [rmf_pkg::CH_W-1:0] red_med;

  // handshake chain
  assign s2_adv       = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign s1_adv       = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;

  // effective geometry
  always_comb begin
    fw_ext = WW'(fw_r);
    if (fw_ext < WW'(W)) begin
      eff_w = WW'(W);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (fh_r < FH_W'(W)) ? FH_W'(W) : fh_r;
  end

  assign last_col = WW'(col_r) >= (eff_w - WW'(1));
  assign last_row = row_r >= (eff_h - FH_W'(1));
  assign emit     = (row_r >= FH_W'(W - 1)) && (col_r >= CW'(W - 1));

  // config registers and raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= rmf_pkg::FW_RESET;
      fh_r  <= rmf_pkg::FH_RESET;
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we) begin
      unique case (rmf_pkg::reg_idx_t'(cfg_index))
        rmf_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_wdata[rmf_pkg::FW_W-1:0];
        rmf_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + FH_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line store: one RAM per buffered line, read at accept, written when
  // the item moves into the window
  for (genvar l = 0; l < NL; l++) begin : g_line
    if (l < NL - 1) begin : g_mid
      assign wr_pix[l] = rd_pix[l + 1];
    end else begin : g_new
      assign wr_pix[l] = s1_pix_r;
    end

    rmf_ram #(
      .WIDTH (rmf_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (s1_adv),
      .waddr (s1_col_r),
      .wdata (wr_pix[l]),
      .re    (accept),
      .raddr (col_r),
      .rdata (rd_pix[l])
    );
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= '{red: in_ch.red, green: in_ch.green, blue: in_ch.blue};
      s1_col_r  <= col_r;
      s1_emit_r <= emit;
      s1_le_r   <= last_col;
      s1_fe_r   <= last_col && last_row;
    end
  end

  // stage 2: window shift; every item shifts, only interior ones emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      for (int r = 0; r < W; r++) begin
        for (int c = 0; c < W; c++) begin
          window_r[r][c] <= '0;
        end
      end
    end else begin
      if (s1_adv) begin
        s2_valid_r <= s1_emit_r;
        for (int r = 0; r < W; r++) begin
          for (int c = 0; c < W - 1; c++) begin
            window_r[r][c] <= window_r[r][c + 1];
          end
        end
        for (int r = 0; r < NL; r++) begin
          window_r[r][W - 1] <= rd_pix[r];
        end
        window_r[NL][W - 1] <= s1_pix_r;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_le_r <= s1_le_r;
      s2_fe_r <= s1_fe_r;
    end
  end

  always_comb begin
    for (int r = 0; r < W; r++) begin
      for (int c = 0; c < W; c++) begin
        blue_s[r * W + c]  = window_r[r][c].blue;
        green_s[r * W + c] = window_r[r][c].green;
        red_s[r * W + c]   = window_r[r][c].red;
      end
    end
  end

  rmf_median u_med_blue  (.samples (blue_s),  .median (blue_med));
  rmf_median u_med_green (.samples (green_s), .median (green_med));
  rmf_median u_med_red   (.samples (red_s),   .median (red_med));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_blue_r  <= blue_med;
      out_green_r <= green_med;
      out_red_r   <= red_med;
      out_le_r    <= s2_le_r;
      out_fe_r    <= s2_fe_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.blue_median  = out_blue_r;
  assign out_ch.green_median = out_green_r;
  assign out_ch.red_median   = out_red_r;
  assign out_ch.line_end     = out_le_r;
  assign out_ch.frame_end    = out_fe_r;

  `RMF_ASSERT_NOW(a_col_in_line, 1'b1, WW'(col_r) < eff_w)
  `RMF_ASSERT_NOW(a_row_in_frame, 1'b1, row_r < eff_h)
  `RMF_ASSERT_NOW(a_fe_needs_le, out_valid_r && out_fe_r, out_le_r)
  `RMF_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_r)
  `RMF_ASSERT_NEXT(a_s2_holds, s2_valid_r && !s2_adv, s2_valid_r)

endmodule

`default_nettype wire
